/* rtl/bsa_pkg.sv */
// Package for the blocked slot allocator.
// Holds field widths, status codes and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package bsa_pkg;

   // Default sizing of the store.
   localparam int DEF_SLOTS_PER_BLOCK = 64;
   localparam int DEF_MAX_BLOCKS      = 16;

   // Fixed field widths of the request and response channels.
   localparam int ADDR_W      = 10;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 11;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 40;
   localparam int RSP_PAD_W   = RSP_DATA_W - ADDR_W - STATUS_W - 2 * COUNT_W;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_FREE  = 2'd1,
      STATUS_EXHAUSTED = 2'd2
   } status_code_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            capture;     // Latch the request and set up the divider.
      logic            scan_read;   // Read the free count of the scanned block.
      logic            scan_next;   // Step the scan to the next older block.
      logic            take_found;  // Select the scanned block for the pop.
      logic            open_new;    // Open the next unopened block.
      logic            fill_write;  // Write one entry of the new block's stack.
      logic            pop;         // Pop the top of the selected block's stack.
      logic            div_step;    // One step of the address division.
      logic            free_read;   // Read the free count of the freed block.
      logic            push;        // Push the freed slot onto its block's stack.
      logic            res_set;     // Record the outcome of the item.
      status_code_type res_code;    // Outcome recorded by res_set.
      logic            emit;        // Load the response register.
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_free;      // The current item frees a slot.
      logic none_open;    // No block is open yet.
      logic idx_zero;     // The scan sits at the oldest block.
      logic fib_nonzero;  // The free count just read is not zero.
      logic all_open;     // Every block is open.
      logic fill_last;    // The stack fill writes its last entry.
      logic div_last;     // The division takes its last step.
      logic blk_bad;      // The freed address lies in an unopened block.
      logic blk_full;     // The freed address lies in a fully free block.
      logic out_free;     // The response register can take a new result.
   } stat_type;

endpackage

/* rtl/bsa_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bsa_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bsa_ctrl.sv */
// Controller of the blocked slot allocator: sequences scan, block open, pop,
// division and push. Depends on bsa_pkg.
`timescale 1ns / 1ps

module bsa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  bsa_pkg::stat_type stat,
   output bsa_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_NO_FREE,
      ST_FILL,
      ST_POP_RD,
      ST_POP_WAIT,
      ST_DIV,
      ST_FREE_RD,
      ST_FREE_CHK,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   // A new item is taken only between items.
   assign req_tready = (state_ff == ST_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.res_code = bsa_pkg::STATUS_OK;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.is_free) begin
               state_in = ST_DIV;
            end else if (stat.none_open) begin
               state_in = ST_NO_FREE;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            cmd.scan_read = 1'b1;
            state_in      = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (stat.fib_nonzero) begin
               cmd.take_found = 1'b1;
               state_in       = ST_POP_RD;
            end else if (stat.idx_zero) begin
               state_in = ST_NO_FREE;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = ST_SCAN_RD;
            end
         end
         ST_NO_FREE: begin
            if (stat.all_open) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = bsa_pkg::STATUS_EXHAUSTED;
               state_in     = ST_FINISH;
            end else begin
               cmd.open_new = 1'b1;
               state_in     = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill_write = 1'b1;
            if (stat.fill_last) begin
               state_in = ST_POP_RD;
            end
         end
         ST_POP_RD: begin
            cmd.pop  = 1'b1;
            state_in = ST_POP_WAIT;
         end
         ST_POP_WAIT: begin
            cmd.res_set  = 1'b1;
            cmd.res_code = bsa_pkg::STATUS_OK;
            state_in     = ST_FINISH;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_FREE_RD;
            end
         end
         ST_FREE_RD: begin
            if (stat.blk_bad) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = bsa_pkg::STATUS_BAD_FREE;
               state_in     = ST_FINISH;
            end else begin
               cmd.free_read = 1'b1;
               state_in      = ST_FREE_CHK;
            end
         end
         ST_FREE_CHK: begin
            cmd.res_set = 1'b1;
            if (stat.blk_full) begin
               cmd.res_code = bsa_pkg::STATUS_BAD_FREE;
            end else begin
               cmd.push     = 1'b1;
               cmd.res_code = bsa_pkg::STATUS_OK;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/bsa_dpath.sv */
// Datapath of the blocked slot allocator: free-count and stack memories,
// address divider, counters and the response register. Depends on bsa_pkg, bsa_ram.
`timescale 1ns / 1ps

module bsa_dpath #(
   parameter int SLOTS_PER_BLOCK = bsa_pkg::DEF_SLOTS_PER_BLOCK,
   parameter int MAX_BLOCKS      = bsa_pkg::DEF_MAX_BLOCKS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bsa_pkg::cmd_type                cmd,
   output bsa_pkg::stat_type               stat,
   input  logic [bsa_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bsa_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int ADDR_W  = bsa_pkg::ADDR_W;
   localparam int COUNT_W = bsa_pkg::COUNT_W;
   localparam int SLOT_W  = $clog2(SLOTS_PER_BLOCK);
   localparam int FREE_W  = $clog2(SLOTS_PER_BLOCK + 1);
   localparam int BLK_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int OPEN_W  = $clog2(MAX_BLOCKS + 1);
   localparam int STORE   = SLOTS_PER_BLOCK * MAX_BLOCKS;
   localparam int STK_AW  = $clog2(STORE);
   localparam int CNT_W   = $clog2(STORE + 1);
   localparam int CMP_W   = (ADDR_W > OPEN_W) ? ADDR_W : OPEN_W;

   // Reciprocal of the block size, rounded up, scaled by 2**DIV_SH.
   localparam int DIV_SH  = ADDR_W + SLOT_W;
   localparam int RECIP_W = ADDR_W + 2;
   localparam int PROD_W  = ADDR_W + RECIP_W;

   localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(SLOTS_PER_BLOCK - 1);
   localparam logic [FREE_W-1:0]  FREE_FULL = FREE_W'(SLOTS_PER_BLOCK);
   localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'(((1 << DIV_SH) + SLOTS_PER_BLOCK - 1) / SLOTS_PER_BLOCK);

   // Item and sequencing registers.
   logic                     mode_ff;
   logic [ADDR_W-1:0]        addr_ff;
   logic [ADDR_W-1:0]        quo_ff;
   logic [SLOT_W-1:0]        rem_ff;
   logic                     div_phase_ff;
   logic [BLK_W-1:0]         idx_ff;
   logic [BLK_W-1:0]         blk_ff;
   logic [FREE_W-1:0]        cnt_ff;
   logic [SLOT_W-1:0]        fill_ff;

   // Allocator state and result registers.
   logic [OPEN_W-1:0]        opened_ff;
   logic [CNT_W-1:0]         live_ff;
   logic [CNT_W-1:0]         peak_ff;
   logic [STK_AW-1:0]        res_addr_ff;
   bsa_pkg::status_code_type res_status_ff;
   logic                     rsp_valid_ff;
   logic [bsa_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // Memory ports.
   logic                     fib_we;
   logic [BLK_W-1:0]         fib_raddr;
   logic [FREE_W-1:0]        fib_wdata;
   logic [FREE_W-1:0]        fib_rdata;
   logic                     stk_we;
   logic [STK_AW-1:0]        stk_waddr;
   logic [SLOT_W-1:0]        stk_wdata;
   logic [STK_AW-1:0]        stk_raddr;
   logic [SLOT_W-1:0]        stk_rdata;

   // Helper values.
   logic [STK_AW-1:0]        base_addr;
   logic [FREE_W-1:0]        cnt_m1;
   logic [PROD_W-1:0]        div_prod;
   logic [ADDR_W-1:0]        div_quo;
   logic [ADDR_W-1:0]        div_back;
   logic [CNT_W-1:0]         live_inc;

   // First stack entry of the selected block.
   assign base_addr = STK_AW'(blk_ff * SLOTS_PER_BLOCK);
   assign cnt_m1    = cnt_ff - FREE_W'(1);
   assign live_inc  = live_ff + CNT_W'(1);

   // Division of the address by the block size: the quotient comes from a
   // multiplication by the reciprocal, the remainder from the product back.
   assign div_prod = PROD_W'(addr_ff) * PROD_W'(DIV_RECIP);
   assign div_quo  = ADDR_W'(div_prod >> DIV_SH);
   assign div_back = ADDR_W'(quo_ff * SLOTS_PER_BLOCK);

   // Free-count memory: scan and free reads, pop and push updates.
   assign fib_raddr = cmd.free_read ? quo_ff[BLK_W-1:0] : idx_ff;
   assign fib_we    = cmd.pop | cmd.push;
   assign fib_wdata = cmd.push ? (fib_rdata + FREE_W'(1)) : cnt_m1;

   bsa_ram #(
      .WIDTH (FREE_W),
      .DEPTH (MAX_BLOCKS)
   ) u_free_count (
      .clock   (clock),
      .wr_en   (fib_we),
      .wr_addr (blk_ff),
      .wr_data (fib_wdata),
      .rd_en   (cmd.scan_read | cmd.free_read),
      .rd_addr (fib_raddr),
      .rd_data (fib_rdata)
   );

   // Stack memory: fill of a new block and push on write, pop on read.
   assign stk_we    = cmd.fill_write | cmd.push;
   assign stk_waddr = cmd.push ? (base_addr + STK_AW'(fib_rdata))
                               : (base_addr + STK_AW'(fill_ff));
   assign stk_wdata = cmd.push ? rem_ff : (SLOT_LAST - fill_ff);
   assign stk_raddr = base_addr + STK_AW'(cnt_m1);

   bsa_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (STORE)
   ) u_free_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (cmd.pop),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   // Status toward the controller.
   always_comb begin
      stat.is_free     = mode_ff;
      stat.none_open   = (opened_ff == '0);
      stat.idx_zero    = (idx_ff == '0);
      stat.fib_nonzero = (fib_rdata != '0);
      stat.all_open    = (opened_ff == OPEN_W'(MAX_BLOCKS));
      stat.fill_last   = (fill_ff == SLOT_LAST);
      stat.div_last    = div_phase_ff;
      stat.blk_bad     = (CMP_W'(quo_ff) >= CMP_W'(opened_ff));
      stat.blk_full    = (fib_rdata >= FREE_FULL);
      stat.out_free    = !rsp_valid_ff || rsp_tready;
   end

   // Item registers, divider, scan index and fill counter.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff      <= req_tuser;
         addr_ff      <= req_tdata[ADDR_W-1:0];
         div_phase_ff <= 1'b0;
         idx_ff       <= BLK_W'(opened_ff - OPEN_W'(1));
      end
      if (cmd.div_step) begin
         if (!div_phase_ff) begin
            quo_ff <= div_quo;
         end else begin
            rem_ff <= SLOT_W'(addr_ff - div_back);
         end
         div_phase_ff <= 1'b1;
      end
      if (cmd.scan_next) begin
         idx_ff <= idx_ff - BLK_W'(1);
      end
      if (cmd.take_found) begin
         blk_ff <= idx_ff;
         cnt_ff <= fib_rdata;
      end
      if (cmd.open_new) begin
         blk_ff  <= BLK_W'(opened_ff);
         cnt_ff  <= FREE_FULL;
         fill_ff <= '0;
      end
      if (cmd.fill_write) begin
         fill_ff <= fill_ff + SLOT_W'(1);
      end
      if (cmd.free_read) begin
         blk_ff <= quo_ff[BLK_W-1:0];
      end
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_code;
         if (cmd.res_code == bsa_pkg::STATUS_OK && !mode_ff) begin
            res_addr_ff <= base_addr + STK_AW'(stk_rdata);
         end else begin
            res_addr_ff <= '0;
         end
      end
   end

   // Block count, live and peak counts.
   always_ff @(posedge clock) begin
      if (reset) begin
         opened_ff <= '0;
         live_ff   <= '0;
         peak_ff   <= '0;
      end else begin
         if (cmd.open_new) begin
            opened_ff <= opened_ff + OPEN_W'(1);
         end
         if (cmd.res_set && cmd.res_code == bsa_pkg::STATUS_OK) begin
            if (!mode_ff) begin
               live_ff <= live_inc;
               if (live_inc > peak_ff) begin
                  peak_ff <= live_inc;
               end
            end else if (live_ff != '0) begin
               live_ff <= live_ff - CNT_W'(1);
            end
         end
      end
   end

   // Response register: holds a result until its transfer completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= {{bsa_pkg::RSP_PAD_W{1'b0}},
                         COUNT_W'(peak_ff),
                         COUNT_W'(live_ff),
                         res_status_ff,
                         ADDR_W'(res_addr_ff)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/blocked_slot_allocator.sv */
// Blocked slot allocator, top level: controller plus datapath.
// Depends on bsa_pkg, bsa_ctrl, bsa_dpath (and bsa_ram below it).
//
// Usage:
//   The request channel carries one item per transfer: req_tuser selects the
//   operation (0 allocate, 1 free) and req_tdata holds the address to free.
//   Every request yields exactly one response on the rsp channel with the
//   allocated address, a status code and the live and peak slot counts.
//   Items are worked one at a time. The steps below run from the
//   request transfer to the loading of the response register; the next
//   request can be taken in the cycle after that load.
//   A free divides the address by the block size (quotient, then remainder),
//   then reads the free count of the address's block and checks it; a free in
//   a block that was never opened skips the read. An allocate reads and checks
//   the free count of each opened block that it scans; opening a new block adds
//   a fill of its stack, one write per cycle. An allocate on a full store
//   answers after it has scanned every block.
//   When the receiver stalls, the result waits in the response register while
//   the next request is taken; that second result then waits in the controller
//   until the register is free, and no further request is taken meanwhile.
//   Reset clears the block count, the live and peak counts and the response
//   valid flag; the memories need no clearing.
`timescale 1ns / 1ps

module blocked_slot_allocator #(
   parameter int SLOTS_PER_BLOCK = bsa_pkg::DEF_SLOTS_PER_BLOCK,
   parameter int MAX_BLOCKS      = bsa_pkg::DEF_MAX_BLOCKS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bsa_pkg::REQ_DATA_W-1:0]  req_tdata,  // [9:0] node_address, rest zero
   input  logic                            req_tuser,  // [0] mode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [9:0] slot_address, [11:10] status, [22:12] live_count, [33:23] peak_count
   output logic [bsa_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   bsa_pkg::cmd_type  cmd;
   bsa_pkg::stat_type stat;

   // Sequencer.
   bsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Storage, arithmetic and response register.
   bsa_dpath #(
      .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK),
      .MAX_BLOCKS      (MAX_BLOCKS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // A pop and a push never share a cycle.
   assert property (@(posedge clock) disable iff (reset) !(cmd.pop && cmd.push))
      else $error("pop and push issued together");

   // After a request transfer the block is busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while an item is in progress");

   // A loaded result is presented on the next cycle.
   assert property (@(posedge clock) disable iff (reset) cmd.emit |=> rsp_tvalid)
      else $error("result loaded but not presented");

   // An exhausted store answers with address zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[11:10] == bsa_pkg::STATUS_EXHAUSTED)
         |-> (rsp_tdata[9:0] == '0))
      else $error("exhausted response carries an address");

endmodule

/* bench/tb_blocked_slot_allocator.sv */
// Self-checking testbench for blocked_slot_allocator: allocate and free requests
// go in, and every response is compared with a built-in allocator prediction.
// Depends on bsa_pkg and the blocked_slot_allocator RTL.
`timescale 1ns / 1ps

module tb_blocked_slot_allocator;

   localparam int SLOTS         = bsa_pkg::DEF_SLOTS_PER_BLOCK;
   localparam int BLOCKS        = bsa_pkg::DEF_MAX_BLOCKS;
   localparam int ADDR_W        = bsa_pkg::ADDR_W;
   localparam int COUNT_W       = bsa_pkg::COUNT_W;
   localparam int REQ_DATA_W    = bsa_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W    = bsa_pkg::RSP_DATA_W;
   localparam int RSP_PAD_W     = bsa_pkg::RSP_PAD_W;
   localparam int STORE_SLOTS   = SLOTS * BLOCKS;
   localparam int RANDOM_ITEMS  = 1580;
   localparam int DRAIN_CYCLES  = 32;
   localparam int CYCLE_LIMIT   = 1200000;
   localparam int REPORT_LIMIT  = 10;
   localparam int FREED_HISTORY = 32;

   // Request operation codes carried on req_tuser.
   localparam bit MODE_ALLOC = 1'b0;
   localparam bit MODE_FREE  = 1'b1;

   // Fields of one response, as the predictor produces them.
   typedef struct packed {
      logic [ADDR_W-1:0]        slot;
      bsa_pkg::status_code_type status;
      logic [COUNT_W-1:0]       live;
      logic [COUNT_W-1:0]       peak;
   } rsp_fields_type;

   // Allocator state mirror plus the queue of responses still due.
   class slot_scoreboard_type;
      logic [5:0]  stack_mem [STORE_SLOTS];
      int unsigned free_count [BLOCKS];
      int unsigned open_count;
      int unsigned live_slots;
      int unsigned peak_slots;
      rsp_fields_type due_q[$];
      int errors;
      int reported;
      int checked;
      int n_alloc;
      int n_free;
      int n_rejected;
      int n_exhausted;

      function new();
         foreach (stack_mem[i]) stack_mem[i] = '0;
         foreach (free_count[i]) free_count[i] = 0;
         open_count  = 0;
         live_slots  = 0;
         peak_slots  = 0;
         errors      = 0;
         reported    = 0;
         checked     = 0;
         n_alloc     = 0;
         n_free      = 0;
         n_rejected  = 0;
         n_exhausted = 0;
      endfunction

      // Works out the response to one accepted request and queues it.
      function rsp_fields_type note_request(bit free_op, logic [ADDR_W-1:0] addr);
         rsp_fields_type r;
         int blk;
         int slot;
         int i;
         bit found;
         r.slot   = '0;
         r.status = bsa_pkg::STATUS_OK;
         if (free_op == MODE_ALLOC) begin
            found = 1'b0;
            blk   = 0;
            i     = open_count;
            // Newest opened block first, down to the oldest.
            while (i > 0 && !found) begin
               i = i - 1;
               if (free_count[i] != 0) begin
                  blk   = i;
                  found = 1'b1;
               end
            end
            if (!found && open_count >= BLOCKS) begin
               r.status = bsa_pkg::STATUS_EXHAUSTED;
               n_exhausted++;
            end else begin
               if (!found) begin
                  // A fresh block pops its slots in ascending order.
                  blk = open_count;
                  for (int k = 0; k < SLOTS; k++)
                     stack_mem[blk * SLOTS + k] = 6'(SLOTS - 1 - k);
                  free_count[blk] = SLOTS;
                  open_count++;
               end
               free_count[blk]--;
               slot   = stack_mem[blk * SLOTS + free_count[blk]];
               r.slot = ADDR_W'(blk * SLOTS + slot);
               live_slots++;
               if (live_slots > peak_slots) peak_slots = live_slots;
               n_alloc++;
            end
         end else begin
            blk  = addr / SLOTS;
            slot = addr % SLOTS;
            if (blk >= open_count || blk >= BLOCKS || free_count[blk] >= SLOTS) begin
               r.status = bsa_pkg::STATUS_BAD_FREE;
               n_rejected++;
            end else begin
               // A repeated free in a partly used block is pushed again.
               stack_mem[blk * SLOTS + free_count[blk]] = 6'(slot);
               free_count[blk]++;
               if (live_slots > 0) live_slots--;
               n_free++;
            end
         end
         r.live = COUNT_W'(live_slots);
         r.peak = COUNT_W'(peak_slots);
         due_q.push_back(r);
         return r;
      endfunction

      // Compares one response transfer with the oldest outstanding prediction.
      function void check_response(logic [RSP_DATA_W-1:0] data);
         rsp_fields_type want;
         rsp_fields_type got;
         logic [RSP_PAD_W-1:0] pad;
         got.slot   = data[9:0];
         got.status = bsa_pkg::status_code_type'(data[11:10]);
         got.live   = data[22:12];
         got.peak   = data[33:23];
         pad        = data[RSP_DATA_W-1:34];
         checked++;
         if (due_q.size() == 0) begin
            errors++;
            if (reported < REPORT_LIMIT) begin
               reported++;
               $display("ERROR: response with nothing outstanding: data=%h", data);
            end
         end else begin
            want = due_q.pop_front();
            if (got.slot !== want.slot || got.status !== want.status ||
                got.live !== want.live || got.peak !== want.peak || pad !== '0) begin
               errors++;
               if (reported < REPORT_LIMIT) begin
                  reported++;
                  $display("ERROR: response %0d mismatch at %0t", checked, $realtime);
                  $display("   expected slot=%0d status=%0d live=%0d peak=%0d pad=0",
                           want.slot, want.status, want.live, want.peak);
                  $display("   actual   slot=%0d status=%0d live=%0d peak=%0d pad=%h",
                           got.slot, got.status, got.live, got.peak, pad);
               end
            end
         end
      endfunction

      function int pending();
         return due_q.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [9:0] node_address, rest zero
   logic                  req_tuser;   // [0] mode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [9:0] slot, [11:10] status, [22:12] live, [33:23] peak

   slot_scoreboard_type sb = new();

   // Addresses believed live and recently freed, used to aim the free requests.
   logic [ADDR_W-1:0] live_addrs[$];
   logic [ADDR_W-1:0] freed_addrs[$];
   bit quiet_mode;
   int cycle_count;

   blocked_slot_allocator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 12 ns clock.
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, sb.pending());
         $display("Verification failed");
         $finish;
      end
   end

   // Idle length: mostly none or short, now and then long, none in quiet stretches.
   function automatic int pick_gap();
      int r;
      if (quiet_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Sends one request, waits for its transfer, then idles for a random gap.
   task automatic issue_request(input bit free_op, input logic [ADDR_W-1:0] addr);
      rsp_fields_type predicted;
      int gap;
      int hit;
      req_tvalid <= 1'b1;
      req_tuser  <= free_op;
      req_tdata  <= {{(REQ_DATA_W - ADDR_W){1'b0}}, addr};
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = sb.note_request(free_op, addr);
      // Keep the address lists in step with what the allocator now holds.
      if (predicted.status == bsa_pkg::STATUS_OK) begin
         if (free_op == MODE_ALLOC) begin
            live_addrs.push_back(predicted.slot);
         end else begin
            hit = -1;
            for (int i = 0; i < live_addrs.size() && hit < 0; i++)
               if (live_addrs[i] == addr) hit = i;
            if (hit >= 0) live_addrs.delete(hit);
            freed_addrs.push_back(addr);
            if (freed_addrs.size() > FREED_HISTORY) void'(freed_addrs.pop_front());
         end
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Response side: checks each transfer and inserts random back-pressure.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      stall      = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            sb.check_response(rsp_tdata);
            stall = pick_gap();
         end else if (stall == 0 && $urandom_range(0, 99) < 3) begin
            stall = pick_gap();
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Request side: directed cases, then a fill, drain and mixed random run.
   initial begin
      int phase;
      int phase_start;
      int alloc_pct;
      int pick;
      logic [ADDR_W-1:0] addr;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = MODE_ALLOC;
      req_tdata   = '0;
      quiet_mode  = 1'b0;
      cycle_count = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Frees before any block is open, including the top address.
      issue_request(MODE_FREE, 10'd0);
      issue_request(MODE_FREE, 10'd1023);
      // First allocations open block zero; the address field is ignored.
      issue_request(MODE_ALLOC, 10'd1023);
      issue_request(MODE_ALLOC, 10'd0);
      issue_request(MODE_ALLOC, 10'h155);
      // Repeated free of one slot in a partly used block is accepted twice.
      issue_request(MODE_FREE, 10'd1);
      issue_request(MODE_FREE, 10'd1);
      issue_request(MODE_ALLOC, 10'h2aa);
      issue_request(MODE_ALLOC, 10'd0);
      // Free everything back until block zero is fully free, then once more.
      issue_request(MODE_FREE, 10'd2);
      issue_request(MODE_FREE, 10'd1);
      issue_request(MODE_FREE, 10'd1);
      issue_request(MODE_FREE, 10'd0);
      // Addresses in blocks that were never opened.
      issue_request(MODE_FREE, 10'd64);
      issue_request(MODE_FREE, 10'd512);
      issue_request(MODE_FREE, 10'h3c0);
      issue_request(MODE_ALLOC, 10'd0);
      issue_request(MODE_ALLOC, 10'd0);
      issue_request(MODE_FREE, 10'd63);

      // Fill until the store has been found exhausted a few times, then drain,
      // then a balanced mix.
      phase       = 0;
      phase_start = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) quiet_mode = ($urandom_range(0, 4) == 0);
         if (phase == 0 && sb.n_exhausted >= 4) begin
            phase       = 1;
            phase_start = n;
         end else if (phase == 1 && n - phase_start >= 280) begin
            phase = 2;
         end
         alloc_pct = (phase == 0) ? 95 : (phase == 1) ? 20 : 55;
         if ($urandom_range(0, 99) < alloc_pct) begin
            issue_request(MODE_ALLOC, 10'($urandom_range(0, 1023)));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 75 && live_addrs.size() > 0)
               addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
            else if (pick < 88 && freed_addrs.size() > 0)
               addr = freed_addrs[$urandom_range(0, freed_addrs.size() - 1)];
            else
               addr = 10'($urandom_range(0, 1023));
            issue_request(MODE_FREE, addr);
         end
      end
      req_tvalid <= 1'b0;

      // Let every outstanding response arrive, then watch for strays.
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d allocations, %0d frees, %0d rejected frees and %0d",
               sb.n_alloc, sb.n_free, sb.n_rejected, sb.n_exhausted);
      $display("requests on a full store; %0d responses checked, peak %0d, %0d errors.",
               sb.checked, sb.peak_slots, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
